/* src/csvfs_pkg.sv */
// shared types, constants and limits of the csv field splitter
package csvfs_pkg;

    localparam int MAX_FIELDS    = 32;
    localparam int MAX_FIELD_LEN = 256;

    localparam int FIELD_IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    localparam logic [FIELD_IDX_W:0] FIELDS_MAX = (FIELD_IDX_W + 1)'(MAX_FIELDS);
    localparam logic [7:0] CHAR_LIMIT =
        8'(((MAX_FIELD_LEN - 1) > 255) ? 255 : (MAX_FIELD_LEN - 1));

    localparam logic [7:0] BYTE_LF       = 8'd10;
    localparam logic [7:0] BYTE_CR       = 8'd13;
    localparam logic [7:0] BYTE_QUOTE    = 8'd34;
    localparam logic [7:0] SEP_RESET     = 8'd44;
    localparam logic       SKIP_RESET    = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR   = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       flush;
    } t_item;

    typedef struct packed {
        logic       skip_header;
        logic [7:0] separator;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_value;
        logic [4:0]  field_number;
        logic [7:0]  char_position;
        logic [31:0] row_number;
        logic [5:0]  fields_in_row;
    } t_result;

endpackage

/* src/csvfs_in_reg.sv */
// input register that holds one item ahead of the parser
module csvfs_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csvfs_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output csvfs_pkg::t_item o_item
);
    import csvfs_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/csvfs_parse.sv */
// parser state and per-byte decode of quoting, separators and row ends
module csvfs_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csvfs_pkg::t_cfg    i_cfg,
    input  csvfs_pkg::t_item   i_item,
    input  logic               i_advance,
    output logic               o_emit,
    output csvfs_pkg::t_result o_result
);
    import csvfs_pkg::*;

    logic                   r_quoted, n_quoted;
    logic                   r_pending, n_pending;
    logic [FIELD_IDX_W-1:0] r_field, n_field;
    logic [7:0]             r_count, n_count;
    logic [31:0]            r_row, n_row;
    logic                   r_header, n_header;
    logic                   r_full, n_full;
    logic                   r_open, n_open;

    logic                   hide;
    logic                   qm_eff;
    logic                   do_append;
    logic                   do_end;
    logic [7:0]             app_char;
    logic [FIELD_IDX_W:0]   field_sum;
    logic                   emit;
    t_kind                  kind;
    logic [7:0]             ch;
    logic [5:0]             fin;

    assign hide      = i_cfg.skip_header && !r_header;
    assign field_sum = {1'b0, r_field} + (FIELD_IDX_W + 1)'(1);

    always_comb begin
        n_quoted  = r_quoted;
        n_pending = r_pending;
        n_field   = r_field;
        n_count   = r_count;
        n_row     = r_row;
        n_header  = r_header;
        n_full    = r_full;
        n_open    = r_open;
        emit      = 1'b0;
        kind      = KIND_CHAR;
        ch        = 8'd0;
        fin       = 6'd0;
        qm_eff    = r_quoted;
        do_append = 1'b0;
        do_end    = 1'b0;
        app_char  = i_item.text_byte;

        if (i_item.flush) begin
            if (r_open) begin
                do_end = 1'b1;
            end
        end else if (i_item.text_byte == BYTE_LF) begin
            do_end = 1'b1;
        end else begin
            n_open = 1'b1;
            if (!r_full) begin
                if (r_pending && i_item.text_byte == BYTE_QUOTE) begin
                    // doubled quote inside quotes
                    n_pending = 1'b0;
                    do_append = 1'b1;
                    app_char  = BYTE_QUOTE;
                end else begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        qm_eff    = 1'b0;
                        n_quoted  = 1'b0;
                    end
                    if (i_item.text_byte == BYTE_QUOTE) begin
                        if (qm_eff) begin
                            n_pending = 1'b1;
                        end else begin
                            n_quoted = 1'b1;
                        end
                    end else if (i_item.text_byte == i_cfg.separator && !qm_eff) begin
                        if (field_sum >= FIELDS_MAX) begin
                            n_full = 1'b1;
                        end else begin
                            emit    = 1'b1;
                            kind    = KIND_FIELD_END;
                            n_field = field_sum[FIELD_IDX_W-1:0];
                            n_count = 8'd0;
                        end
                    end else if (i_item.text_byte != BYTE_CR) begin
                        do_append = 1'b1;
                    end
                end
            end
        end

        if (do_append && r_count < CHAR_LIMIT) begin
            emit    = 1'b1;
            kind    = KIND_CHAR;
            ch      = app_char;
            n_count = r_count + 8'd1;
        end

        if (do_end) begin
            emit      = 1'b1;
            kind      = KIND_ROW_END;
            fin       = 6'(field_sum);
            if (!hide) begin
                n_row = r_row + 32'd1;
            end
            n_header  = 1'b1;
            n_quoted  = 1'b0;
            n_pending = 1'b0;
            n_field   = '0;
            n_count   = 8'd0;
            n_full    = 1'b0;
            n_open    = 1'b0;
        end
    end

    always_comb begin
        o_emit                 = emit && !hide;
        o_result.kind          = kind;
        o_result.char_value    = ch;
        o_result.field_number  = 5'(r_field);
        o_result.char_position = r_count;
        o_result.row_number    = r_row;
        o_result.fields_in_row = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted  <= 1'b0;
            r_pending <= 1'b0;
            r_field   <= '0;
            r_count   <= 8'd0;
            r_row     <= 32'd0;
            r_header  <= 1'b0;
            r_full    <= 1'b0;
            r_open    <= 1'b0;
        end else if (i_advance) begin
            r_quoted  <= n_quoted;
            r_pending <= n_pending;
            r_field   <= n_field;
            r_count   <= n_count;
            r_row     <= n_row;
            r_header  <= n_header;
            r_full    <= n_full;
            r_open    <= n_open;
        end
    end

    a_pending_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_quoted)
        else $error("quote pending outside quoted mode");

    a_full_row_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_open)
        else $error("row full without an open row");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CHAR_LIMIT)
        else $error("character count beyond limit");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && do_end) |=> (r_field == '0 && r_count == 8'd0 && !r_open
                                   && !r_quoted && r_header))
        else $error("row end did not clear row state");

endmodule

/* src/csvfs_out_reg.sv */
// result register toward the output channel
module csvfs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  csvfs_pkg::t_result i_result,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output csvfs_pkg::t_result o_result
);
    import csvfs_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* src/csv_field_splitter.sv */
// top level of the csv field splitter: config registers, input and result stages
// One text byte (or a flush item) is accepted per clock cycle while the result
// side keeps up. An item passes an input register and then the parser, whose
// quote, field and row state updates once per item: one item per cycle. A result
// is registered as its item leaves the input register. Each item gives zero or
// one result; items that give none (CR, quotes, dropped text) still pass the
// parser. There is no clearing pass after reset. The user must write skip_header
// (index 0) and separator (index 1) only while idle; this is not enforced.
module csv_field_splitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_text_byte,
    input  logic                              i_flush,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [7:0]                        o_char_value,
    output logic [4:0]                        o_field_number,
    output logic [7:0]                        o_char_position,
    output logic [31:0]                       o_row_number,
    output logic [5:0]                        o_fields_in_row
);
    import csvfs_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    out_space;
    logic    advance;
    logic    emit;
    t_result parse_result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.skip_header <= SKIP_RESET;
            r_cfg.separator   <= SEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SKIP_HEADER: r_cfg.skip_header <= i_cfg_data[0];
                CFG_SEPARATOR:   r_cfg.separator   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign in_item.text_byte = i_text_byte;
    assign in_item.flush     = i_flush;
    assign advance           = stage_valid && out_space;

    csvfs_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    csvfs_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (stage_item),
        .i_advance (advance),
        .o_emit    (emit),
        .o_result  (parse_result)
    );

    csvfs_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (parse_result),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_char_value    = out_result.char_value;
    assign o_field_number  = out_result.field_number;
    assign o_char_position = out_result.char_position;
    assign o_row_number    = out_result.row_number;
    assign o_fields_in_row = out_result.fields_in_row;

endmodule
